/* src/olist_pkg.sv */
// Package for the ordered list engine: word types, command and status codes,
// and the control word broadcast to the row of storage cells. No dependencies.
package olist_pkg;

    // Width of positions and counts carried to the cells; covers up to 127 entries.
    localparam int CTL_W = 7;
    localparam int LEN_W = 5;
    localparam int VAL_W = 32;

    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_APPEND = 3'd1;
    localparam logic [2:0] CMD_INSERT = 3'd2;
    localparam logic [2:0] CMD_REMOVE = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;
    localparam logic [2:0] CMD_DUMP   = 3'd5;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]              cmd;
        logic [4:0]              position;
        logic signed [VAL_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] element;
        logic                    last;
        logic [LEN_W-1:0]        length;
    } out_word_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                op;
        logic [CTL_W-1:0]        pos;
        logic [CTL_W-1:0]        count;
        logic signed [VAL_W-1:0] din;
    } cell_ctl_t;

endpackage

/* src/olist_cell.sv */
// One storage cell of the list: holds one element and takes its next value
// from itself, its left or right neighbor, the new value or the head cell.
// Depends on olist_pkg.
module olist_cell import olist_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic                    aclk,
    input  cell_ctl_t               ctl,
    input  logic signed [VAL_W-1:0] left_val,
    input  logic signed [VAL_W-1:0] right_val,
    input  logic signed [VAL_W-1:0] head_val,
    output logic signed [VAL_W-1:0] val
);

    localparam logic [CTL_W-1:0] MyIdx  = CTL_W'(IDX);
    localparam logic [CTL_W-1:0] MyIdx1 = CTL_W'(IDX + 1);

    logic signed [VAL_W-1:0] val_reg;
    logic signed [VAL_W-1:0] val_next;

    always_comb begin
        val_next = val_reg;
        case (ctl.op)
            CELL_INSERT: begin
                if (MyIdx == ctl.pos) begin
                    val_next = ctl.din;
                end else if (MyIdx > ctl.pos) begin
                    val_next = left_val;
                end
            end
            CELL_REMOVE: begin
                if (MyIdx1 < ctl.count) begin
                    val_next = right_val;
                end
            end
            CELL_ROTATE: begin
                // The occupied part of the row turns left by one place.
                if (MyIdx1 < ctl.count) begin
                    val_next = right_val;
                end else if (MyIdx1 == ctl.count) begin
                    val_next = head_val;
                end
            end
            default: begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

/* src/ordered_list_engine_unit.sv */
// Top level of the ordered list engine: command decode, element count, dump
// sequencer, result register and the row of olist_cell storage cells.
// Depends on olist_pkg and olist_cell.
//
//   Channel | Ports                        | Word
//   --------+------------------------------+------------------------------------
//   command | s_valid, s_ready, s_data     | in_word_t  (cmd, position, value)
//   result  | m_valid, m_ready, m_data     | out_word_t (status, element, last,
//           |                              |             length)
//
// Every command except a dump of a non-empty list is done in the cycle it is
// accepted: all cells shift at once, so the result word is valid on the next
// cycle and a new command can be taken in that same cycle if the result side
// is taking words. A dump of N elements gives N words, one per cycle while
// the result side takes them; each word rotates the occupied cells by one
// place, so the list is back in order after the last word. No command is
// accepted during a dump. Reset clears the count and the control state; the
// cells themselves are not cleared, since nothing reads a cell at or above
// the count. A stall on the result side holds the result word and blocks new
// commands until it is taken.
module ordered_list_engine_unit import olist_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int BW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   count_reg;
    logic [BW-1:0]   beat_reg;
    logic            m_valid_reg;
    out_word_t       m_data_reg;

    logic            accept;
    logic            out_free;
    logic            start_dump;
    logic            last_beat;
    logic [1:0]      status_c;
    logic [CW-1:0]   count_next;
    logic [CTL_W-1:0] cnt_ext;
    logic [CTL_W-1:0] cnt_next_ext;
    logic [CTL_W-1:0] pos_eff;
    cell_ctl_t       ctl;

    logic signed [VAL_W-1:0] cell_val [CAPACITY];

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign cnt_ext  = CTL_W'(count_reg);
    assign cnt_next_ext = CTL_W'(count_next);
    assign last_beat = (CTL_W'(beat_reg) + CTL_W'(1)) == cnt_ext;

    // Push inserts at the front, append at the current end.
    always_comb begin
        case (s_data.cmd)
            CMD_PUSH:   pos_eff = '0;
            CMD_APPEND: pos_eff = cnt_ext;
            default:    pos_eff = CTL_W'(s_data.position);
        endcase
    end

    // Command decode: status, new count and the operation for the cells.
    always_comb begin
        ctl.op     = CELL_HOLD;
        ctl.pos    = pos_eff;
        ctl.count  = cnt_ext;
        ctl.din    = s_data.value;
        status_c   = STAT_OK;
        count_next = count_reg;
        start_dump = 1'b0;
        if (state_reg == S_DUMP) begin
            if (out_free) begin
                ctl.op = CELL_ROTATE;
            end
        end else if (accept) begin
            case (s_data.cmd)
                CMD_PUSH, CMD_APPEND, CMD_INSERT: begin
                    // An index past the end is checked before a full list.
                    if (pos_eff > cnt_ext) begin
                        status_c = STAT_RANGE;
                    end else if (cnt_ext == CTL_W'(CAPACITY)) begin
                        status_c = STAT_FULL;
                    end else begin
                        ctl.op     = CELL_INSERT;
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_REMOVE: begin
                    if (count_reg == '0) begin
                        status_c = STAT_EMPTY;
                    end else begin
                        ctl.op     = CELL_REMOVE;
                        count_next = count_reg - CW'(1);
                    end
                end
                CMD_CLEAR: begin
                    if (count_reg == '0) begin
                        status_c = STAT_EMPTY;
                    end else begin
                        count_next = '0;
                    end
                end
                CMD_DUMP: begin
                    if (count_reg == '0) begin
                        status_c = STAT_EMPTY;
                    end else begin
                        start_dump = 1'b1;
                    end
                end
                default: begin
                    status_c = STAT_OK;
                end
            endcase
        end
    end

    // State, count, dump beat and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            beat_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        count_reg <= count_next;
                        if (start_dump) begin
                            // An accept means any held word is being taken now.
                            state_reg   <= S_DUMP;
                            beat_reg    <= '0;
                            m_valid_reg <= 1'b0;
                        end else begin
                            m_valid_reg        <= 1'b1;
                            m_data_reg.status  <= status_c;
                            m_data_reg.element <= '0;
                            m_data_reg.last    <= 1'b1;
                            m_data_reg.length  <= cnt_next_ext[LEN_W-1:0];
                        end
                    end else if (m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                end
                S_DUMP: begin
                    if (out_free) begin
                        m_valid_reg        <= 1'b1;
                        m_data_reg.status  <= STAT_OK;
                        m_data_reg.element <= cell_val[0];
                        m_data_reg.last    <= last_beat;
                        m_data_reg.length  <= cnt_ext[LEN_W-1:0];
                        beat_reg           <= beat_reg + BW'(1);
                        if (last_beat) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The row of cells; cell 0 is the head of the list.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [VAL_W-1:0] left_val;
        logic signed [VAL_W-1:0] right_val;
        if (i == 0) begin : g_first
            assign left_val = ctl.din;
        end else begin : g_mid_l
            assign left_val = cell_val[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_val = cell_val[i];
        end else begin : g_mid_r
            assign right_val = cell_val[i+1];
        end
        olist_cell #(
            .IDX(i)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .left_val  (left_val),
            .right_val (right_val),
            .head_val  (cell_val[0]),
            .val       (cell_val[i])
        );
    end

`ifndef ASSERT_OFF
    // No command may slip in while a dump is streaming.
    a_no_accept_in_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DUMP) |-> !s_ready)
        else $error("command accepted during dump");

    // The count stays within the number of cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CTL_W'(count_reg) <= CTL_W'(CAPACITY))
        else $error("element count above capacity");

    // Any command other than dump gives one final word on the next cycle.
    a_single_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.cmd != CMD_DUMP)) |=> (m_valid && m_data.last))
        else $error("missing single result word");

    // A dump only ends once its final word is loaded.
    a_dump_end: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(state_reg) == S_DUMP && state_reg == S_IDLE) |-> (m_valid && m_data.last))
        else $error("dump ended without final word");
`endif

endmodule
